### design/tcw_pkg.sv
// Package for the text console writer: transaction payload types, codes,
// controller states, datapath operations and the datapath status group.
// No dependencies.
package tcw_pkg;

  // Input transaction payload
  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  ch;
    logic [11:0] read_addr;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic [11:0] cursor_pos;
    logic [11:0] view_start;
    logic [1:0]  search_mode;
    logic [7:0]  cell_char;
    logic [7:0]  cell_color;
  } out_item_t;

  // One cell of the store
  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] color;
  } cell_t;

  // Command codes
  localparam logic [2:0] CMD_PUT    = 3'd0;
  localparam logic [2:0] CMD_UP     = 3'd1;
  localparam logic [2:0] CMD_DOWN   = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  // Key codes
  localparam logic [7:0] KEY_ESC   = 8'd27;
  localparam logic [7:0] KEY_TAB   = 8'd9;
  localparam logic [7:0] KEY_NL    = 8'd10;
  localparam logic [7:0] KEY_BS    = 8'd8;
  localparam logic [7:0] KEY_SPACE = 8'd32;

  // Search modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_TYPING = 2'd1;
  localparam logic [1:0] MODE_FROZEN = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_NORMAL    = 2'd0;
  localparam logic [1:0] REG_HIDDEN    = 2'd1;
  localparam logic [1:0] REG_HIGHLIGHT = 2'd2;

  // Color reset values
  localparam logic [7:0] RST_NORMAL    = 8'd7;
  localparam logic [7:0] RST_HIDDEN    = 8'd0;
  localparam logic [7:0] RST_HIGHLIGHT = 8'd4;

  // Controller states
  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_READ,
    ST_TAB,
    ST_NL,
    ST_BS_CHK,
    ST_BS_TAB,
    ST_BS_NL_RD,
    ST_BS_NL_CHK,
    ST_SRCH,
    ST_SRCH_CHK,
    ST_HL_RD,
    ST_HL_WR,
    ST_RST_RD,
    ST_RST_WR,
    ST_RST_ERASE,
    ST_SCROLL,
    ST_DONE
  } state_e;

  // Datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT_WR,
    OP_LOAD,
    OP_CLEAR_START,
    OP_CLEAR_WR,
    OP_READ_ISSUE,
    OP_READ_CAP,
    OP_VIEW_UP,
    OP_VIEW_DOWN,
    OP_ESC_OPEN,
    OP_ESC_CLOSE,
    OP_TAB_WR,
    OP_NL_WR,
    OP_CHAR_WR,
    OP_NL_START,
    OP_BS_RD,
    OP_ERASE,
    OP_CMP_RD,
    OP_CMP_NEXT,
    OP_MISS,
    OP_HIT,
    OP_HL_RD,
    OP_HL_WR,
    OP_RST_RD,
    OP_RST_WR,
    OP_EMIT
  } dp_op_e;

  // Datapath status toward the controller
  typedef struct packed {
    logic sweep_last;
    logic is_put;
    logic is_up;
    logic is_down;
    logic is_clear;
    logic is_read;
    logic is_esc;
    logic is_tab;
    logic is_nl;
    logic is_bs;
    logic mode_normal;
    logic mode_typing;
    logic mode_frozen;
    logic tab_room;
    logic nl_room;
    logic char_room;
    logic bs_block;
    logic cur_zero;
    logic col_last;
    logic tab_cnt_last;
    logic nl_cnt_full;
    logic rd_tab;
    logic rd_nl;
    logic srch_empty;
    logic p_done;
    logic i_done;
    logic cmp_ok;
    logic above;
    logic scroll_need;
    logic addr_ok;
    logic out_free;
  } dp_status_t;

endpackage

### design/tcw_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write port and registered reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### design/tcw_ctrl.sv
// Controller state machine of the text console writer.
// Depends on tcw_pkg; drives one datapath operation per cycle.
module tcw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tcw_pkg::dp_status_t status_i,
  output tcw_pkg::dp_op_e     op_o
);

  tcw_pkg::state_e state_q, state_d;

  // State register; reset starts the store clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcw_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != tcw_pkg::ST_IDLE);

  // Next state and operation
  always_comb begin
    state_d = state_q;
    op_o    = tcw_pkg::OP_NONE;
    case (state_q)
      tcw_pkg::ST_INIT: begin
        op_o = tcw_pkg::OP_INIT_WR;
        if (status_i.sweep_last) state_d = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          op_o    = tcw_pkg::OP_LOAD;
          state_d = tcw_pkg::ST_DECODE;
        end
      end
      tcw_pkg::ST_DECODE: begin
        state_d = tcw_pkg::ST_DONE;
        if (status_i.is_put) begin
          state_d = tcw_pkg::ST_SCROLL;
          if (status_i.is_esc) begin
            if (status_i.mode_normal) begin
              op_o = tcw_pkg::OP_ESC_OPEN;
            end else begin
              op_o    = tcw_pkg::OP_ESC_CLOSE;
              state_d = tcw_pkg::ST_RST_RD;
            end
          end else if (status_i.mode_frozen) begin
            op_o = tcw_pkg::OP_NONE;
          end else if (status_i.is_tab) begin
            if (status_i.tab_room) state_d = tcw_pkg::ST_TAB;
          end else if (status_i.is_nl) begin
            if (status_i.nl_room) begin
              if (status_i.mode_typing) begin
                op_o    = tcw_pkg::OP_NL_START;
                state_d = tcw_pkg::ST_SRCH;
              end else begin
                state_d = tcw_pkg::ST_NL;
              end
            end
          end else if (status_i.is_bs) begin
            if (!status_i.bs_block && !status_i.cur_zero) begin
              op_o    = tcw_pkg::OP_BS_RD;
              state_d = tcw_pkg::ST_BS_CHK;
            end
          end else if (status_i.char_room) begin
            op_o = tcw_pkg::OP_CHAR_WR;
          end
        end else if (status_i.is_up) begin
          op_o = tcw_pkg::OP_VIEW_UP;
        end else if (status_i.is_down) begin
          op_o = tcw_pkg::OP_VIEW_DOWN;
        end else if (status_i.is_clear) begin
          op_o    = tcw_pkg::OP_CLEAR_START;
          state_d = tcw_pkg::ST_CLEAR;
        end else if (status_i.is_read && status_i.addr_ok) begin
          op_o    = tcw_pkg::OP_READ_ISSUE;
          state_d = tcw_pkg::ST_READ;
        end
      end
      tcw_pkg::ST_CLEAR: begin
        op_o = tcw_pkg::OP_CLEAR_WR;
        if (status_i.sweep_last) state_d = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_READ: begin
        op_o    = tcw_pkg::OP_READ_CAP;
        state_d = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_TAB: begin
        op_o = tcw_pkg::OP_TAB_WR;
        if (status_i.tab_cnt_last) state_d = tcw_pkg::ST_SCROLL;
      end
      tcw_pkg::ST_NL: begin
        op_o = tcw_pkg::OP_NL_WR;
        if (status_i.col_last) state_d = tcw_pkg::ST_SCROLL;
      end
      // Backspace: classify the cell left of the cursor
      tcw_pkg::ST_BS_CHK: begin
        if (status_i.rd_tab) begin
          state_d = tcw_pkg::ST_BS_TAB;
        end else if (status_i.rd_nl) begin
          op_o    = tcw_pkg::OP_ERASE;
          state_d = tcw_pkg::ST_BS_NL_RD;
        end else begin
          op_o    = tcw_pkg::OP_ERASE;
          state_d = tcw_pkg::ST_SCROLL;
        end
      end
      tcw_pkg::ST_BS_TAB: begin
        if (status_i.cur_zero) begin
          state_d = tcw_pkg::ST_SCROLL;
        end else begin
          op_o = tcw_pkg::OP_ERASE;
          if (status_i.tab_cnt_last) state_d = tcw_pkg::ST_SCROLL;
        end
      end
      tcw_pkg::ST_BS_NL_RD: begin
        if (status_i.cur_zero || status_i.nl_cnt_full) begin
          state_d = tcw_pkg::ST_SCROLL;
        end else begin
          op_o    = tcw_pkg::OP_BS_RD;
          state_d = tcw_pkg::ST_BS_NL_CHK;
        end
      end
      tcw_pkg::ST_BS_NL_CHK: begin
        if (status_i.rd_nl) begin
          op_o    = tcw_pkg::OP_ERASE;
          state_d = tcw_pkg::ST_BS_NL_RD;
        end else begin
          state_d = tcw_pkg::ST_SCROLL;
        end
      end
      // Search: read each text and pattern cell pair in ST_SRCH, then compare it in ST_SRCH_CHK
      tcw_pkg::ST_SRCH: begin
        if (status_i.srch_empty || status_i.p_done) begin
          state_d = tcw_pkg::ST_SCROLL;
        end else if (status_i.i_done) begin
          op_o    = tcw_pkg::OP_HIT;
          state_d = tcw_pkg::ST_HL_RD;
        end else begin
          op_o    = tcw_pkg::OP_CMP_RD;
          state_d = tcw_pkg::ST_SRCH_CHK;
        end
      end
      tcw_pkg::ST_SRCH_CHK: begin
        op_o    = status_i.cmp_ok ? tcw_pkg::OP_CMP_NEXT : tcw_pkg::OP_MISS;
        state_d = tcw_pkg::ST_SRCH;
      end
      tcw_pkg::ST_HL_RD: begin
        if (status_i.i_done) begin
          op_o    = tcw_pkg::OP_HIT;
          state_d = tcw_pkg::ST_SRCH;
        end else begin
          op_o    = tcw_pkg::OP_HL_RD;
          state_d = tcw_pkg::ST_HL_WR;
        end
      end
      tcw_pkg::ST_HL_WR: begin
        op_o    = tcw_pkg::OP_HL_WR;
        state_d = tcw_pkg::ST_HL_RD;
      end
      // Restore: recolor cells below the pattern, then erase it
      tcw_pkg::ST_RST_RD: begin
        if (status_i.p_done) begin
          state_d = tcw_pkg::ST_RST_ERASE;
        end else begin
          op_o    = tcw_pkg::OP_RST_RD;
          state_d = tcw_pkg::ST_RST_WR;
        end
      end
      tcw_pkg::ST_RST_WR: begin
        op_o    = tcw_pkg::OP_RST_WR;
        state_d = tcw_pkg::ST_RST_RD;
      end
      tcw_pkg::ST_RST_ERASE: begin
        if (status_i.above) begin
          op_o = tcw_pkg::OP_ERASE;
        end else begin
          state_d = tcw_pkg::ST_SCROLL;
        end
      end
      tcw_pkg::ST_SCROLL: begin
        if (status_i.scroll_need) begin
          op_o = tcw_pkg::OP_VIEW_DOWN;
        end else begin
          state_d = tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          op_o    = tcw_pkg::OP_EMIT;
          state_d = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### design/tcw_dp.sv
// Datapath of the text console writer: cell store, cursor, view, search
// registers, color registers and the result register.
// Depends on tcw_pkg and tcw_ram.
module tcw_dp #(
  parameter int CELLS        = 4096,
  parameter int COLUMNS      = 80,
  parameter int SCREEN_CELLS = 2000,
  parameter int TAB_CELLS    = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [7:0]          cfg_wdata_i,
  input  tcw_pkg::in_item_t   in_data_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output tcw_pkg::out_item_t  out_data_o,
  input  tcw_pkg::dp_op_e     op_i,
  output tcw_pkg::dp_status_t status_o
);

  localparam int AW  = $clog2(CELLS);
  localparam int WW  = $clog2(2 * CELLS + SCREEN_CELLS + COLUMNS + TAB_CELLS) + 1;
  localparam int CLW = $clog2(COLUMNS);
  localparam int CNW = $clog2(COLUMNS + TAB_CELLS + 1);
  localparam logic [WW-1:0] CELLS_W  = WW'(CELLS);
  localparam logic [WW-1:0] SCREEN_W = WW'(SCREEN_CELLS);
  localparam logic [WW-1:0] COLS_W   = WW'(COLUMNS);
  localparam logic [WW-1:0] TAB_W    = WW'(TAB_CELLS);

  logic [AW-1:0]     cursor_q, cursor_d;
  logic [CLW-1:0]    col_q, col_d;
  logic [WW-1:0]     view_q, view_d;
  logic [1:0]        mode_q, mode_d;
  logic [AW-1:0]     ps_q, ps_d;
  logic [WW-1:0]     p_q, p_d;
  logic [AW-1:0]     i_q, i_d;
  logic [CNW-1:0]    cnt_q, cnt_d;
  logic              oob_q, oob_d;
  logic [7:0]        normal_q, hidden_q, hl_q;
  logic [7:0]        rd_ch_q, rd_ch_d, rd_col_q, rd_col_d;
  logic              out_valid_q, out_valid_d;
  tcw_pkg::in_item_t  item_q, item_d;
  tcw_pkg::out_item_t out_q, out_d;

  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  tcw_pkg::cell_t wdata, rdata_a, rdata_b;

  logic [WW-1:0] cur_w, p_plus_i, view_end;
  logic [AW-1:0] len;
  logic [CLW-1:0] col_inc, col_dec;

  tcw_ram #(.WIDTH($bits(tcw_pkg::cell_t)), .DEPTH(CELLS)) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Shared arithmetic
  assign cur_w    = WW'(cursor_q);
  assign p_plus_i = p_q + WW'(i_q);
  assign view_end = view_q + SCREEN_W;
  assign len      = cursor_q - ps_q;
  assign col_inc  = (col_q == CLW'(COLUMNS - 1)) ? '0 : col_q + CLW'(1);
  assign col_dec  = (col_q == '0) ? CLW'(COLUMNS - 1) : col_q - CLW'(1);

  // Status toward the controller
  always_comb begin
    status_o.sweep_last   = (p_q == WW'(CELLS - 1));
    status_o.is_put       = (item_q.cmd == tcw_pkg::CMD_PUT);
    status_o.is_up        = (item_q.cmd == tcw_pkg::CMD_UP);
    status_o.is_down      = (item_q.cmd == tcw_pkg::CMD_DOWN);
    status_o.is_clear     = (item_q.cmd == tcw_pkg::CMD_CLEAR);
    status_o.is_read      = (item_q.cmd == tcw_pkg::CMD_READ);
    status_o.is_esc       = (item_q.ch == tcw_pkg::KEY_ESC);
    status_o.is_tab       = (item_q.ch == tcw_pkg::KEY_TAB);
    status_o.is_nl        = (item_q.ch == tcw_pkg::KEY_NL);
    status_o.is_bs        = (item_q.ch == tcw_pkg::KEY_BS);
    status_o.mode_normal  = (mode_q == tcw_pkg::MODE_NORMAL);
    status_o.mode_typing  = (mode_q == tcw_pkg::MODE_TYPING);
    status_o.mode_frozen  = (mode_q == tcw_pkg::MODE_FROZEN);
    status_o.tab_room     = (cur_w + TAB_W < CELLS_W);
    status_o.nl_room      = (cur_w + COLS_W < CELLS_W);
    status_o.char_room    = (cur_w + WW'(1) < CELLS_W);
    status_o.bs_block     = (mode_q == tcw_pkg::MODE_TYPING) && (ps_q >= cursor_q);
    status_o.cur_zero     = (cursor_q == '0);
    status_o.col_last     = (col_q == CLW'(COLUMNS - 1));
    status_o.tab_cnt_last = (cnt_q == CNW'(TAB_CELLS - 1));
    status_o.nl_cnt_full  = (cnt_q == CNW'(COLUMNS));
    status_o.rd_tab       = (rdata_a.ch == tcw_pkg::KEY_TAB);
    status_o.rd_nl        = (rdata_a.ch == tcw_pkg::KEY_NL);
    status_o.srch_empty   = (cursor_q <= ps_q);
    status_o.p_done       = (p_q >= WW'(ps_q));
    status_o.i_done       = (i_q == len);
    status_o.cmp_ok       = !oob_q && (rdata_a.ch == rdata_b.ch);
    status_o.above        = (cursor_q > ps_q);
    status_o.scroll_need  = (cur_w >= view_end) && (view_end < CELLS_W);
    status_o.addr_ok      = (WW'(item_q.read_addr) < CELLS_W);
    status_o.out_free     = !out_valid_q || !out_stall_i;
  end

  // Operation decode
  always_comb begin
    cursor_d    = cursor_q;
    col_d       = col_q;
    view_d      = view_q;
    mode_d      = mode_q;
    ps_d        = ps_q;
    p_d         = p_q;
    i_d         = i_q;
    cnt_d       = cnt_q;
    oob_d       = oob_q;
    item_d      = item_q;
    rd_ch_d     = rd_ch_q;
    rd_col_d    = rd_col_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    we          = 1'b0;
    waddr       = cursor_q;
    wdata       = '{ch: tcw_pkg::KEY_SPACE, color: normal_q};
    raddr_a     = cursor_q - AW'(1);
    raddr_b     = ps_q + i_q;
    case (op_i)
      tcw_pkg::OP_INIT_WR: begin
        we    = 1'b1;
        waddr = p_q[AW-1:0];
        wdata = '{ch: tcw_pkg::KEY_SPACE, color: tcw_pkg::RST_NORMAL};
        p_d   = p_q + WW'(1);
      end
      tcw_pkg::OP_LOAD: begin
        item_d   = in_data_i;
        cnt_d    = '0;
        rd_ch_d  = '0;
        rd_col_d = '0;
      end
      tcw_pkg::OP_CLEAR_START: begin
        p_d      = '0;
        cursor_d = '0;
        col_d    = '0;
        view_d   = '0;
      end
      tcw_pkg::OP_CLEAR_WR: begin
        we    = 1'b1;
        waddr = p_q[AW-1:0];
        p_d   = p_q + WW'(1);
      end
      tcw_pkg::OP_READ_ISSUE: begin
        raddr_a = AW'(item_q.read_addr);
      end
      tcw_pkg::OP_READ_CAP: begin
        rd_ch_d  = rdata_a.ch;
        rd_col_d = rdata_a.color;
      end
      tcw_pkg::OP_VIEW_UP: begin
        if (view_q != '0) view_d = (view_q >= COLS_W) ? view_q - COLS_W : '0;
      end
      tcw_pkg::OP_VIEW_DOWN: begin
        if (view_end < CELLS_W) view_d = view_q + COLS_W;
      end
      tcw_pkg::OP_ESC_OPEN: begin
        ps_d   = cursor_q;
        mode_d = tcw_pkg::MODE_TYPING;
      end
      tcw_pkg::OP_ESC_CLOSE: begin
        mode_d = tcw_pkg::MODE_NORMAL;
        p_d    = '0;
      end
      tcw_pkg::OP_TAB_WR: begin
        we       = 1'b1;
        wdata    = '{ch: tcw_pkg::KEY_TAB, color: hidden_q};
        cursor_d = cursor_q + AW'(1);
        col_d    = col_inc;
        cnt_d    = cnt_q + CNW'(1);
      end
      tcw_pkg::OP_NL_WR: begin
        we       = 1'b1;
        wdata    = '{ch: tcw_pkg::KEY_NL, color: hidden_q};
        cursor_d = cursor_q + AW'(1);
        col_d    = col_inc;
      end
      tcw_pkg::OP_CHAR_WR: begin
        we       = 1'b1;
        wdata    = '{ch: item_q.ch,
                     color: (mode_q == tcw_pkg::MODE_NORMAL) ? normal_q : hl_q};
        cursor_d = cursor_q + AW'(1);
        col_d    = col_inc;
      end
      tcw_pkg::OP_NL_START: begin
        mode_d = tcw_pkg::MODE_FROZEN;
        p_d    = '0;
        i_d    = '0;
      end
      tcw_pkg::OP_BS_RD: begin
        raddr_a = cursor_q - AW'(1);
      end
      // Step back one cell and blank it
      tcw_pkg::OP_ERASE: begin
        we       = 1'b1;
        waddr    = cursor_q - AW'(1);
        cursor_d = cursor_q - AW'(1);
        col_d    = col_dec;
        cnt_d    = cnt_q + CNW'(1);
      end
      tcw_pkg::OP_CMP_RD: begin
        raddr_a = p_plus_i[AW-1:0];
        oob_d   = (p_plus_i >= CELLS_W);
      end
      tcw_pkg::OP_CMP_NEXT: begin
        i_d = i_q + AW'(1);
      end
      tcw_pkg::OP_MISS: begin
        p_d = p_q + WW'(1);
        i_d = '0;
      end
      tcw_pkg::OP_HIT: begin
        i_d = '0;
      end
      tcw_pkg::OP_HL_RD: begin
        raddr_a = p_q[AW-1:0];
      end
      // Tab cells inside a match keep their color
      tcw_pkg::OP_HL_WR: begin
        we    = (rdata_a.ch != tcw_pkg::KEY_TAB);
        waddr = p_q[AW-1:0];
        wdata = '{ch: rdata_a.ch, color: hl_q};
        p_d   = p_q + WW'(1);
        i_d   = i_q + AW'(1);
      end
      tcw_pkg::OP_RST_RD: begin
        raddr_a = p_q[AW-1:0];
      end
      tcw_pkg::OP_RST_WR: begin
        we    = (rdata_a.ch != tcw_pkg::KEY_TAB) && (rdata_a.ch != tcw_pkg::KEY_NL);
        waddr = p_q[AW-1:0];
        wdata = '{ch: rdata_a.ch, color: normal_q};
        p_d   = p_q + WW'(1);
      end
      tcw_pkg::OP_EMIT: begin
        out_valid_d       = 1'b1;
        out_d.cursor_pos  = 12'(cursor_q);
        out_d.view_start  = 12'(view_q);
        out_d.search_mode = mode_q;
        out_d.cell_char   = rd_ch_q;
        out_d.cell_color  = rd_col_q;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      col_q       <= '0;
      view_q      <= '0;
      mode_q      <= tcw_pkg::MODE_NORMAL;
      ps_q        <= '0;
      p_q         <= '0;
      i_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cursor_q    <= cursor_d;
      col_q       <= col_d;
      view_q      <= view_d;
      mode_q      <= mode_d;
      ps_q        <= ps_d;
      p_q         <= p_d;
      i_q         <= i_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Color registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_q <= tcw_pkg::RST_NORMAL;
      hidden_q <= tcw_pkg::RST_HIDDEN;
      hl_q     <= tcw_pkg::RST_HIGHLIGHT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tcw_pkg::REG_NORMAL:    normal_q <= cfg_wdata_i;
        tcw_pkg::REG_HIDDEN:    hidden_q <= cfg_wdata_i;
        tcw_pkg::REG_HIGHLIGHT: hl_q     <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    oob_q    <= oob_d;
    rd_ch_q  <= rd_ch_d;
    rd_col_q <= rd_col_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/text_console_writer_with_search.sv
// A put also scrolls the view down row by row until the cursor is on screen or the view
// reaches the store end. Search compares the pattern with the cells below it and highlights
// each match; restore recolors the cells below the pattern and then erases the pattern.
// One transaction is in work at a time; the next can be accepted in the same cycle that the result shows.
// Reset: control clears at once, then a sweep blanks every cell of the store; config is taken.
module text_console_writer_with_search #(
  parameter int CELLS        = 4096,
  parameter int COLUMNS      = 80,
  parameter int SCREEN_CELLS = 2000,
  parameter int TAB_CELLS    = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tcw_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tcw_pkg::out_item_t out_data_o
);

  tcw_pkg::dp_op_e     op;
  tcw_pkg::dp_status_t status;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .op_o       (op)
  );

  tcw_dp #(
    .CELLS        (CELLS),
    .COLUMNS      (COLUMNS),
    .SCREEN_CELLS (SCREEN_CELLS),
    .TAB_CELLS    (TAB_CELLS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .op_i        (op),
    .status_o    (status)
  );

`ifndef SYNTHESIS
  // One transaction at a time: accept closes the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a transaction is in work");

  // A new result only appears at the end of a transaction in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a transaction in work");

  // Search mode stays in its three codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.search_mode != 2'd3))
    else $error("bad search mode");
`endif

endmodule

### tb/sv/console_checker.sv
// Checker for the text console writer: follows both transaction channels and
// the configuration port, predicts each result and compares it field by field.
// Depends on tcw_pkg.
`timescale 1ns / 100ps
module console_checker #(
  parameter int CELLS        = 4096,
  parameter int COLUMNS      = 80,
  parameter int SCREEN_CELLS = 2000,
  parameter int TAB_CELLS    = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  tcw_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  tcw_pkg::out_item_t out_data_i,
  output int                 fail_cnt_o,
  output int                 pending_o,
  output int                 search_cnt_o
);

  // Predicted console state
  logic [7:0] scr_chr [CELLS];
  logic [7:0] scr_col [CELLS];
  int         cur;
  int         vbase;
  logic [1:0] smode;
  int         pstart;
  logic [7:0] col_normal, col_hidden, col_hl;

  tcw_pkg::out_item_t expected_q [$];

  function automatic void blank_cell(int i);
    scr_chr[i] = tcw_pkg::KEY_SPACE;
    scr_col[i] = col_normal;
  endfunction

  function automatic void erase_back();
    if (cur > 0) begin
      cur--;
      blank_cell(cur);
    end
  endfunction

  function automatic void scroll_down();
    if (vbase + SCREEN_CELLS < CELLS) vbase += COLUMNS;
  endfunction

  // Highlight every non-overlapping match of the pattern in cells below it
  function automatic void run_search();
    int len, p, i;
    bit same;
    search_cnt_o++;
    if (cur <= pstart) return;
    len = cur - pstart;
    p = 0;
    while (p < pstart) begin
      same = 1;
      for (i = 0; i < len; i++) begin
        if (p + i >= CELLS || scr_chr[p + i] != scr_chr[pstart + i]) begin
          same = 0;
          break;
        end
      end
      if (same) begin
        for (i = 0; i < len; i++) begin
          if (p < CELLS && scr_chr[p] != tcw_pkg::KEY_TAB) scr_col[p] = col_hl;
          p++;
        end
      end else begin
        p++;
      end
    end
  endfunction

  // Give colors back and erase the pattern text
  function automatic void run_restore();
    for (int p = 0; p < pstart && p < CELLS; p++)
      if (scr_chr[p] != tcw_pkg::KEY_TAB && scr_chr[p] != tcw_pkg::KEY_NL)
        scr_col[p] = col_normal;
    while (cur > pstart) erase_back();
  endfunction

  function automatic void apply_key(logic [7:0] key);
    int nxt, prev_vbase;
    if (smode == tcw_pkg::MODE_FROZEN && key != tcw_pkg::KEY_ESC) return;
    if (key == tcw_pkg::KEY_ESC) begin
      if (smode == tcw_pkg::MODE_NORMAL) begin
        pstart = cur;
        smode  = tcw_pkg::MODE_TYPING;
      end else begin
        smode = tcw_pkg::MODE_NORMAL;
        run_restore();
      end
    end else if (key == tcw_pkg::KEY_TAB) begin
      if (cur + TAB_CELLS < CELLS)
        for (int i = 0; i < TAB_CELLS; i++) begin
          scr_chr[cur] = tcw_pkg::KEY_TAB;
          scr_col[cur] = col_hidden;
          cur++;
        end
    end else if (key == tcw_pkg::KEY_NL) begin
      if (cur + COLUMNS < CELLS) begin
        if (smode == tcw_pkg::MODE_TYPING) begin
          smode = tcw_pkg::MODE_FROZEN;
          run_search();
        end else begin
          nxt = (cur / COLUMNS + 1) * COLUMNS;
          while (cur < nxt) begin
            scr_chr[cur] = tcw_pkg::KEY_NL;
            scr_col[cur] = col_hidden;
            cur++;
          end
        end
      end
    end else if (key == tcw_pkg::KEY_BS) begin
      if (smode == tcw_pkg::MODE_TYPING && pstart >= cur) return;
      if (cur > 0) begin
        if (scr_chr[cur - 1] == tcw_pkg::KEY_TAB) begin
          for (int i = 0; i < TAB_CELLS; i++) erase_back();
        end else if (scr_chr[cur - 1] == tcw_pkg::KEY_NL) begin
          for (int i = 0; i < COLUMNS && cur > 0 && scr_chr[cur - 1] == tcw_pkg::KEY_NL; i++)
            erase_back();
        end else begin
          erase_back();
        end
      end
    end else if (cur + 1 < CELLS) begin
      scr_chr[cur] = key;
      scr_col[cur] = (smode == tcw_pkg::MODE_NORMAL) ? col_normal : col_hl;
      cur++;
    end
    // keep the cursor on screen
    while (cur >= vbase + SCREEN_CELLS) begin
      prev_vbase = vbase;
      scroll_down();
      if (vbase == prev_vbase) break;
    end
  endfunction

  function automatic tcw_pkg::out_item_t console_step(tcw_pkg::in_item_t it);
    tcw_pkg::out_item_t r;
    r.cell_char  = '0;
    r.cell_color = '0;
    case (it.cmd)
      tcw_pkg::CMD_PUT:  apply_key(it.ch);
      tcw_pkg::CMD_UP:   if (vbase > 0) vbase = (vbase >= COLUMNS) ? vbase - COLUMNS : 0;
      tcw_pkg::CMD_DOWN: scroll_down();
      tcw_pkg::CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) blank_cell(i);
        cur   = 0;
        vbase = 0;
      end
      tcw_pkg::CMD_READ: if (it.read_addr < CELLS) begin
        r.cell_char  = scr_chr[it.read_addr];
        r.cell_color = scr_col[it.read_addr];
      end
      default: ;
    endcase
    r.cursor_pos  = cur[11:0];
    r.view_start  = vbase[11:0];
    r.search_mode = smode;
    return r;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt_o++;
    end
  endtask

  // Sample all channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    tcw_pkg::out_item_t e;
    if (!rst_ni) begin
      col_normal = tcw_pkg::RST_NORMAL;
      col_hidden = tcw_pkg::RST_HIDDEN;
      col_hl     = tcw_pkg::RST_HIGHLIGHT;
      for (int i = 0; i < CELLS; i++) blank_cell(i);
      cur = 0;
      vbase = 0;
      smode = tcw_pkg::MODE_NORMAL;
      pstart = 0;
      expected_q.delete();
      fail_cnt_o   = 0;
      search_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tcw_pkg::REG_NORMAL:    col_normal = cfg_wdata_i;
          tcw_pkg::REG_HIDDEN:    col_hidden = cfg_wdata_i;
          tcw_pkg::REG_HIGHLIGHT: col_hl     = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with no expectation pending");
          fail_cnt_o++;
        end else begin
          e = expected_q.pop_front();
          check_field("cursor_pos", e.cursor_pos, out_data_i.cursor_pos);
          check_field("view_start", e.view_start, out_data_i.view_start);
          check_field("search_mode", e.search_mode, out_data_i.search_mode);
          check_field("cell_char", e.cell_char, out_data_i.cell_char);
          check_field("cell_color", e.cell_color, out_data_i.cell_color);
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(console_step(in_data_i));
    end
    pending_o = expected_q.size();
  end

endmodule

### tb/sv/testbench.sv
// Top of the console writer testbench: clock, reset, stimulus, configuration
// phases, stall pressure and verdict. Depends on tcw_pkg, console_checker and the block.
`timescale 1ns / 100ps
module testbench;

  localparam int ITEMS      = 1250;
  localparam int STALL_LIMIT = 400000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               cfg_we = 0;
  logic [1:0]         cfg_idx = tcw_pkg::REG_NORMAL;
  logic [7:0]         cfg_wdata = '0;
  logic               in_valid = 0;
  logic               in_stall;
  tcw_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 0;
  tcw_pkg::out_item_t out_data;
  int                 fail_cnt, pending, search_cnt;
  logic               in_fire = 0;
  int                 sent = 0, cfg_phases = 0, idle_run = 0;
  int                 hold_left = 0;
  bit                 hold_done = 0;
  bit                 calm_tx = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  text_console_writer_with_search u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  console_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_cnt_o(fail_cnt), .pending_o(pending), .search_cnt_o(search_cnt)
  );

  // Input handshake flag, read at the falling edge
  always @(posedge clk) begin
    in_fire <= in_valid && !in_stall;
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (in_valid && !in_stall || out_valid && !out_stall) idle_run = 0;
    else idle_run++;
    if (idle_run >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off, one calm window
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && sent >= 350) begin
      out_stall <= 1'b1;
      hold_left = 599;
      hold_done = 1'b1;
    end else if (sent >= 500 && sent < 700) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 17);
    end
  end

  task automatic send(logic [2:0] cmd, logic [7:0] ch = '0, logic [11:0] addr = '0);
    if (!calm_tx)
      while ($urandom_range(99) < 17) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    in_valid <= 1'b1;
    in_data  <= '{cmd: cmd, ch: ch, read_addr: addr};
    do @(negedge clk); while (!in_fire);
    sent++;
  endtask

  task automatic key(logic [7:0] ch);
    send(tcw_pkg::CMD_PUT, ch);
  endtask

  task automatic read_cell();
    send(tcw_pkg::CMD_READ, '0,
         ($urandom_range(1) != 0) ? 12'($urandom_range(199)) : 12'($urandom));
  endtask

  // Pause the sender until every result is back, then set the colors
  task automatic set_colors(logic [7:0] n, logic [7:0] h, logic [7:0] l);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= tcw_pkg::REG_NORMAL;    cfg_wdata <= n; @(negedge clk);
    cfg_idx <= tcw_pkg::REG_HIDDEN;    cfg_wdata <= h; @(negedge clk);
    cfg_idx <= tcw_pkg::REG_HIGHLIGHT; cfg_wdata <= l; @(negedge clk);
    cfg_we <= 1'b0;
    cfg_phases++;
  endtask

  function automatic logic [7:0] text_char();
    case ($urandom_range(9))
      0, 1, 2: return "a";
      3, 4:    return "b";
      5:       return tcw_pkg::KEY_SPACE;
      6:       return tcw_pkg::KEY_TAB;
      7:       return 8'($urandom_range(32, 126));
      default: return "c";
    endcase
  endfunction

  // Plain text, then a search on a short pattern, then restore
  task automatic search_session();
    int n;
    n = $urandom_range(3, 40);
    repeat (n) begin
      case ($urandom_range(19))
        0:       key(tcw_pkg::KEY_NL);
        1:       key(tcw_pkg::KEY_BS);
        2:       read_cell();
        default: key(text_char());
      endcase
    end
    key(tcw_pkg::KEY_ESC);
    n = $urandom_range(0, 3);
    repeat (n) key(text_char());
    if ($urandom_range(3) == 0) key(tcw_pkg::KEY_BS);
    key(tcw_pkg::KEY_NL);
    repeat ($urandom_range(1, 5)) read_cell();
    if ($urandom_range(3) == 0) key(text_char());
    key(tcw_pkg::KEY_ESC);
    if ($urandom_range(2) == 0) read_cell();
  endtask

  // Drive the cursor to the store end so every room check fails
  task automatic fill_session();
    repeat (52) key(tcw_pkg::KEY_NL);
    repeat (18) key("z");
    key(tcw_pkg::KEY_TAB);
    key(tcw_pkg::KEY_NL);
    repeat (4) begin
      key("y");
      send(tcw_pkg::CMD_READ, '0, 12'd4095 - 12'($urandom_range(3)));
    end
    key(tcw_pkg::KEY_ESC);
    key(tcw_pkg::KEY_NL);
    key(tcw_pkg::KEY_ESC);
    send(tcw_pkg::CMD_CLEAR);
  endtask

  task automatic noise_item();
    case ($urandom_range(9))
      0:       send(tcw_pkg::CMD_UP);
      1:       send(tcw_pkg::CMD_DOWN);
      2:       send(3'($urandom_range(5, 7)), 8'($urandom), 12'($urandom));
      3, 4:    read_cell();
      5:       if ($urandom_range(9) == 0) send(tcw_pkg::CMD_CLEAR); else key(tcw_pkg::KEY_BS);
      default: key(8'($urandom));
    endcase
  endtask

  initial begin
    int fills;
    fills = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    set_colors(tcw_pkg::RST_NORMAL, tcw_pkg::RST_HIDDEN, tcw_pkg::RST_HIGHLIGHT);

    // Directed: field extremes, every command, the special cases
    send(tcw_pkg::CMD_READ, '0, 12'd0);
    key(8'h00);
    key(8'hFF);
    key(tcw_pkg::KEY_TAB);
    key(tcw_pkg::KEY_BS);     // removes the whole tab
    key(tcw_pkg::KEY_NL);
    key(tcw_pkg::KEY_BS);     // removes the newline run
    send(3'd5, 8'hFF, 12'hFFF);
    send(3'd7);
    send(tcw_pkg::CMD_UP);    // already at the top
    send(tcw_pkg::CMD_DOWN);
    send(tcw_pkg::CMD_UP);
    key(tcw_pkg::KEY_ESC);
    key(tcw_pkg::KEY_BS);     // blocked at pattern start
    key(tcw_pkg::KEY_NL);     // empty pattern
    key("q");                 // frozen, ignored
    key(tcw_pkg::KEY_ESC);
    key(tcw_pkg::KEY_ESC);
    key(8'h00);
    key(tcw_pkg::KEY_NL);     // pattern found before it
    send(tcw_pkg::CMD_READ, '0, 12'd0);
    key(tcw_pkg::KEY_ESC);
    send(tcw_pkg::CMD_CLEAR);
    key(tcw_pkg::KEY_BS);     // at cell zero
    send(tcw_pkg::CMD_READ, '0, 12'hFFF);

    set_colors(8'hFF, 8'hFF, 8'h00);
    fill_session();

    // Random part
    while (sent < ITEMS) begin
      calm_tx = (sent >= 500 && sent < 700);
      if (sent / 300 >= cfg_phases) begin
        case (cfg_phases % 3)
          0:       set_colors(8'h00, 8'h00, 8'hFF);
          1:       set_colors(8'($urandom), 8'($urandom), 8'($urandom));
          default: set_colors(8'hFF, 8'h80, 8'h01);
        endcase
      end
      case ($urandom_range(19))
        0:       if (fills < 4) begin fill_session(); fills++; end else noise_item();
        1, 2, 3: noise_item();
        default: search_session();
      endcase
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("covered %0d input transactions, %0d searches, %0d color settings",
             sent, search_cnt, cfg_phases);
    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
